// ===== rtl/core/lpbs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpbs_pkg: shared types and constants for the parallel LCD bus sequencer
// Command codes, bus index bytes, descriptor layout and strobe counts.
// ---------------------------------------------------------------------------
package lpbs_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [7:0] IDX_PREFIX = 8'h00;
   localparam logic [7:0] IDX_GRAM   = 8'h22;
   localparam logic [7:0] IDX_XADDR  = 8'h21;
   localparam logic [7:0] IDX_YADDR  = 8'h20;

   typedef enum logic [2:0] {
      CMD_WREG = 3'd0,
      CMD_RIDX = 3'd1,
      CMD_RSMP = 3'd2,
      CMD_PIX  = 3'd3,
      CMD_ADDR = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      K_WREG,
      K_RIDX,
      K_RHI,
      K_RLO,
      K_IGN,
      K_PIX,
      K_ADDR
   } kind_type;

   // w0: data word, x address, {red, green} or assembled read value
   // w1: y address or {blue, 8'h00}
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  arg;
      logic [15:0] w0;
      logic [15:0] w1;
   } desc_type;

   function automatic logic [2:0] last_step(input kind_type kind);
      logic [2:0] n;
      unique case (kind)
         K_WREG:  n = 3'd3;
         K_RIDX:  n = 3'd1;
         K_PIX:   n = 3'd4;
         K_ADDR:  n = 3'd7;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/lpbs_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpbs_front: command intake and classification
// Tracks the register read in progress and turns each defined command beat into
// one strobe-run descriptor for the queue.
// ---------------------------------------------------------------------------
module lpbs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [2:0]         req_tuser,   // command
   input  logic [87:0]        req_tdata,   // reg_index, data_word, red, green, blue,
                                           // x_pos, y_pos, bus_byte
   input  logic               q_full,
   output logic               q_push,
   output lpbs_pkg::desc_type q_desc
);
   import lpbs_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HI   = 2'd1,
      PH_LO   = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   logic [7:0]  reg_index;
   logic [15:0] data_word;
   logic [7:0]  red, green, blue, bus_byte;
   logic [15:0] x_pos, y_pos;
   logic        accept, cmd_ok;

   assign reg_index = req_tdata[7:0];
   assign data_word = req_tdata[23:8];
   assign red       = req_tdata[31:24];
   assign green     = req_tdata[39:32];
   assign blue      = req_tdata[47:40];
   assign x_pos     = req_tdata[63:48];
   assign y_pos     = req_tdata[79:64];
   assign bus_byte  = req_tdata[87:80];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && cmd_ok;

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      cmd_ok      = 1'b1;
      q_desc.kind = K_IGN;
      q_desc.arg  = reg_index;
      q_desc.w0   = 16'h0000;
      q_desc.w1   = 16'h0000;
      unique case (cmd_type'(req_tuser))
         CMD_WREG: begin
            phase_in    = PH_IDLE;
            q_desc.kind = K_WREG;
            q_desc.w0   = data_word;
         end
         CMD_RIDX: begin
            phase_in    = PH_HI;
            q_desc.kind = K_RIDX;
         end
         CMD_RSMP: begin
            unique case (phase_ff)
               PH_HI: begin
                  phase_in    = PH_LO;
                  held_in     = bus_byte;
                  q_desc.kind = K_RHI;
               end
               PH_LO: begin
                  phase_in    = PH_IDLE;
                  q_desc.kind = K_RLO;
                  q_desc.w0   = {held_ff, bus_byte};
               end
               default: q_desc.kind = K_IGN;
            endcase
         end
         CMD_PIX: begin
            phase_in    = PH_IDLE;
            q_desc.kind = K_PIX;
            q_desc.w0   = {red, green};
            q_desc.w1   = {blue, 8'h00};
         end
         CMD_ADDR: begin
            phase_in    = PH_IDLE;
            q_desc.kind = K_ADDR;
            q_desc.w0   = x_pos;
            q_desc.w1   = y_pos;
         end
         default: cmd_ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== rtl/core/lpbs_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpbs_queue: descriptor queue between intake and bus sequencer
// Small register-array FIFO with a first-word view of its head.
// ---------------------------------------------------------------------------
module lpbs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpbs_pkg::desc_type push_desc,
   input  logic               pop,
   output lpbs_pkg::desc_type head_desc,
   output logic               full,
   output logic               empty
);
   import lpbs_pkg::*;

   desc_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push dropped");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

// ===== rtl/core/lpbs_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpbs_back: bus strobe sequencer
// Walks the head descriptor one strobe per unstalled cycle to output register.
// ---------------------------------------------------------------------------
module lpbs_back (
   input  logic               clock,
   input  logic               reset,
   input  lpbs_pkg::desc_type head_desc,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [1:0]         rsp_tuser,   // rs_level, is_read
   output logic [31:0]        rsp_tdata,   // byte_out, release_cs, read_value,
                                           // read_valid, status, zero fill
   output logic               rsp_tlast
);
   import lpbs_pkg::*;

   logic [2:0]  step_ff;
   logic        valid_ff;
   logic        rs_ff, rd_ff, rel_ff, vld_ff, st_ff, last_ff;
   logic [7:0]  byte_ff;
   logic [15:0] val_ff;

   logic        load, end_run;
   logic        rs_in, rd_in, rel_in, vld_in, st_in;
   logic [7:0]  byte_in, reg_sel;
   logic [15:0] val_in, word_sel;

   assign load    = !q_empty && (!valid_ff || rsp_tready);
   assign end_run = (step_ff == last_step(head_desc.kind));
   assign q_pop   = load && end_run;

   always_comb begin
      rs_in    = 1'b0;
      rd_in    = 1'b0;
      rel_in   = 1'b0;
      vld_in   = 1'b0;
      st_in    = 1'b0;
      byte_in  = 8'h00;
      val_in   = 16'h0000;
      reg_sel  = head_desc.arg;
      word_sel = head_desc.w0;
      if (head_desc.kind == K_ADDR) begin
         reg_sel  = step_ff[2] ? IDX_YADDR : IDX_XADDR;
         word_sel = step_ff[2] ? head_desc.w1 : head_desc.w0;
      end
      unique case (head_desc.kind) inside
         K_WREG, K_ADDR: begin
            unique case (step_ff[1:0])
               2'd0: byte_in = IDX_PREFIX;
               2'd1: byte_in = reg_sel;
               2'd2: begin
                  rs_in   = 1'b1;
                  byte_in = word_sel[15:8];
               end
               default: begin
                  rs_in   = 1'b1;
                  byte_in = word_sel[7:0];
                  rel_in  = 1'b1;
               end
            endcase
         end
         K_RIDX: byte_in = step_ff[0] ? head_desc.arg : IDX_PREFIX;
         K_RHI: begin
            rs_in = 1'b1;
            rd_in = 1'b1;
         end
         K_RLO: begin
            rs_in  = 1'b1;
            rd_in  = 1'b1;
            rel_in = 1'b1;
            vld_in = 1'b1;
            val_in = head_desc.w0;
         end
         K_PIX: begin
            unique case (step_ff)
               3'd0: byte_in = IDX_PREFIX;
               3'd1: byte_in = IDX_GRAM;
               3'd2: begin
                  rs_in   = 1'b1;
                  byte_in = head_desc.w0[15:8];
               end
               3'd3: begin
                  rs_in   = 1'b1;
                  byte_in = head_desc.w0[7:0];
               end
               default: begin
                  rs_in   = 1'b1;
                  byte_in = head_desc.w1[15:8];
                  rel_in  = 1'b1;
               end
            endcase
         end
         default: st_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            step_ff <= end_run ? 3'd0 : step_ff + 3'd1;
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rs_ff   <= rs_in;
         rd_ff   <= rd_in;
         rel_ff  <= rel_in;
         vld_ff  <= vld_in;
         st_ff   <= st_in;
         byte_ff <= byte_in;
         val_ff  <= val_in;
         last_ff <= end_run;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = {rd_ff, rs_ff};
   assign rsp_tdata  = {5'b00000, st_ff, vld_ff, val_ff, rel_ff, byte_ff};
   assign rsp_tlast  = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && vld_ff) |-> (rel_ff && last_ff && rd_ff))
      else $error("read completion without chip select release");

   assert property (@(posedge clock) disable iff (reset)
      (step_ff != 3'd0) |-> !q_empty)
      else $error("strobe run lost its descriptor");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (valid_ff && last_ff))
      else $error("descriptor retired without final strobe");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && st_ff) |-> (last_ff && !rd_ff && (byte_ff == 8'h00)))
      else $error("ignored sample carries bus activity");

endmodule

// ===== rtl/core/parallel_lcd_bus_sequencer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// parallel_lcd_bus_sequencer_core: 8080-style 8-bit display bus master
// Turns register, pixel, address and read commands into bus strobe beats.
//
// Command channel (req_): one beat per command, command code in tuser and
// its operands in tdata. Codes 5 to 7 are taken and dropped.
// Strobe channel (rsp_): one beat per bus strobe, RS and read flags in
// tuser, byte, chip-select release, read value and status in tdata; tlast
// marks the final strobe of a command.
// A command's first strobe passes through the descriptor queue and then the
// strobe register. The sequencer emits one beat per cycle unless rsp_ stalls,
// so a command takes 1 to 8 beats: 4 for a register write, 2 for a read
// index phase, 1 for a read sample, 5 for a pixel and 8 for an address set.
// A four-entry descriptor queue decouples intake from the sequencer; req_
// stalls only when it is full. A stall on rsp_ holds the strobe register
// and backs up into the queue. Reset empties the queue, drops any pending
// read and clears the output register valid.
// ---------------------------------------------------------------------------
module parallel_lcd_bus_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,    // command
   input  logic [87:0] req_tdata,    // reg_index, data_word, red, green, blue,
                                     // x_pos, y_pos, bus_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,    // rs_level, is_read
   output logic [31:0] rsp_tdata,    // byte_out, release_cs, read_value,
                                     // read_valid, status, zero fill
   output logic        rsp_tlast
);
   import lpbs_pkg::*;

   desc_type push_desc, head_desc;
   logic     push, pop, full, empty;

   lpbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (full),
      .q_push     (push),
      .q_desc     (push_desc)
   );

   lpbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .full      (full),
      .empty     (empty)
   );

   lpbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (head_desc),
      .q_empty    (empty),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the parallel LCD bus sequencer core
// Sends register writes, pixel writes, address sets, read sequences,
// orphan read samples and undefined codes, then checks every strobe beat
// field by field against an in-bench model of the bus sequencer.
// ---------------------------------------------------------------------------
module tb;
   import lpbs_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_ITEMS = 285;
   localparam int REPORT_MAX   = 10;

   localparam logic [2:0] CMD_RSV_FIRST = 3'd5;
   localparam logic [2:0] CMD_RSV_MID   = 3'd6;
   localparam logic [2:0] CMD_RSV_LAST  = 3'd7;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_WANT_HI,
      RD_WANT_LO
   } rd_phase_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  reg_index;
      logic [15:0] data_word;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] x_pos;
      logic [15:0] y_pos;
      logic [7:0]  bus_byte;
   } cmd_item_type;

   typedef struct packed {
      logic        rs_level;
      logic        is_read;
      logic [7:0]  byte_out;
      logic        release_cs;
      logic [15:0] read_value;
      logic        read_valid;
      logic        status;
      logic        last;
   } strobe_type;

   typedef struct packed {
      cmd_item_type item;
      logic         pinned;
      strobe_type   final_strobe;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   strobe_type   strobes_due[$];
   dir_row_type  dir_rows[$];
   rd_phase_type read_state = RD_IDLE;
   logic [7:0]   read_hi_byte = '0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 9;
   int           recv_idle_pct = 78;

   parallel_lcd_bus_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic cmd_item_type mk_cmd(logic [2:0] command, logic [7:0] reg_index,
                                           logic [15:0] data_word, logic [7:0] red,
                                           logic [7:0] green, logic [7:0] blue,
                                           logic [15:0] x_pos, logic [15:0] y_pos,
                                           logic [7:0] bus_byte);
      cmd_item_type c;
      c.command   = command;
      c.reg_index = reg_index;
      c.data_word = data_word;
      c.red       = red;
      c.green     = green;
      c.blue      = blue;
      c.x_pos     = x_pos;
      c.y_pos     = y_pos;
      c.bus_byte  = bus_byte;
      return c;
   endfunction

   function automatic strobe_type mk_strobe(logic rs_level, logic is_read,
                                            logic [7:0] byte_out, logic release_cs,
                                            logic [15:0] read_value, logic read_valid,
                                            logic status, logic last);
      strobe_type s;
      s.rs_level   = rs_level;
      s.is_read    = is_read;
      s.byte_out   = byte_out;
      s.release_cs = release_cs;
      s.read_value = read_value;
      s.read_valid = read_valid;
      s.status     = status;
      s.last       = last;
      return s;
   endfunction

   function automatic cmd_item_type rand_cmd(logic [2:0] command);
      return mk_cmd(command, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endfunction

   function automatic logic [2:0] rand_write_kind();
      int pick;
      pick = $urandom_range(2);
      if (pick == 0) begin
         return CMD_WREG;
      end else if (pick == 1) begin
         return CMD_PIX;
      end
      return CMD_ADDR;
   endfunction

   task automatic push_strobe(logic rs_level, logic is_read, logic [7:0] byte_out,
                              logic release_cs, logic [15:0] read_value,
                              logic read_valid, logic status);
      strobes_due.push_back(mk_strobe(rs_level, is_read, byte_out, release_cs,
                                      read_value, read_valid, status, 1'b0));
   endtask

   task automatic push_reg_write(logic [7:0] index, logic [15:0] word);
      push_strobe(1'b0, 1'b0, IDX_PREFIX, 1'b0, '0, 1'b0, 1'b0);
      push_strobe(1'b0, 1'b0, index, 1'b0, '0, 1'b0, 1'b0);
      push_strobe(1'b1, 1'b0, word[15:8], 1'b0, '0, 1'b0, 1'b0);
      push_strobe(1'b1, 1'b0, word[7:0], 1'b1, '0, 1'b0, 1'b0);
   endtask

   // expected bus strobes for one accepted command, oldest first
   task automatic predict_strobes(input cmd_item_type c);
      int         depth_before;
      strobe_type tail;
      depth_before = strobes_due.size();
      case (c.command)
         CMD_WREG: begin
            read_state = RD_IDLE;
            push_reg_write(c.reg_index, c.data_word);
         end
         CMD_RIDX: begin
            push_strobe(1'b0, 1'b0, IDX_PREFIX, 1'b0, '0, 1'b0, 1'b0);
            push_strobe(1'b0, 1'b0, c.reg_index, 1'b0, '0, 1'b0, 1'b0);
            read_state = RD_WANT_HI;
         end
         CMD_RSMP: begin
            if (read_state == RD_WANT_HI) begin
               read_hi_byte = c.bus_byte;
               read_state   = RD_WANT_LO;
               push_strobe(1'b1, 1'b1, 8'h00, 1'b0, '0, 1'b0, 1'b0);
            end else if (read_state == RD_WANT_LO) begin
               read_state = RD_IDLE;
               push_strobe(1'b1, 1'b1, 8'h00, 1'b1, {read_hi_byte, c.bus_byte}, 1'b1, 1'b0);
            end else begin
               push_strobe(1'b0, 1'b0, 8'h00, 1'b0, '0, 1'b0, 1'b1);
            end
         end
         CMD_PIX: begin
            read_state = RD_IDLE;
            push_strobe(1'b0, 1'b0, IDX_PREFIX, 1'b0, '0, 1'b0, 1'b0);
            push_strobe(1'b0, 1'b0, IDX_GRAM, 1'b0, '0, 1'b0, 1'b0);
            push_strobe(1'b1, 1'b0, c.red, 1'b0, '0, 1'b0, 1'b0);
            push_strobe(1'b1, 1'b0, c.green, 1'b0, '0, 1'b0, 1'b0);
            push_strobe(1'b1, 1'b0, c.blue, 1'b1, '0, 1'b0, 1'b0);
         end
         CMD_ADDR: begin
            read_state = RD_IDLE;
            push_reg_write(IDX_XADDR, c.x_pos);
            push_reg_write(IDX_YADDR, c.y_pos);
         end
         default: begin
         end
      endcase
      if (strobes_due.size() > depth_before) begin
         tail = strobes_due.pop_back();
         tail.last = 1'b1;
         strobes_due.push_back(tail);
      end
   endtask

   task automatic send_cmd(input cmd_item_type c, input logic pinned,
                           input strobe_type final_strobe);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.command;
      req_tdata  <= {c.bus_byte, c.y_pos, c.x_pos, c.blue, c.green, c.red,
                     c.data_word, c.reg_index};
      do @(posedge clock); while (!req_tready);
      predict_strobes(c);
      if (pinned && strobes_due.size() > 0) begin
         void'(strobes_due.pop_back());
         strobes_due.push_back(final_strobe);
      end
   endtask

   task automatic send_rand(input logic [2:0] command);
      send_cmd(rand_cmd(command), 1'b0, '0);
   endtask

   task automatic add_row(input cmd_item_type c, input logic pinned,
                          input strobe_type final_strobe);
      dir_row_type r;
      r.item         = c;
      r.pinned       = pinned;
      r.final_strobe = final_strobe;
      dir_rows.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      strobe_type got;
      strobe_type want;
      logic       bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mk_strobe(rsp_tuser[0], rsp_tuser[1], rsp_tdata[7:0], rsp_tdata[8],
                         rsp_tdata[24:9], rsp_tdata[25], rsp_tdata[26], rsp_tlast);
         if (strobes_due.size() == 0) begin
            if (mismatch_count < REPORT_MAX) begin
               $display("unexpected strobe beat: %p", got);
            end
            mismatch_count <= mismatch_count + 1;
         end else begin
            want = strobes_due.pop_front();
            bad = (got.rs_level !== want.rs_level) || (got.is_read !== want.is_read)
               || (got.byte_out !== want.byte_out) || (got.release_cs !== want.release_cs)
               || (got.read_value !== want.read_value) || (got.read_valid !== want.read_valid)
               || (got.status !== want.status) || (got.last !== want.last);
            if (bad) begin
               if (mismatch_count < REPORT_MAX) begin
                  $display("strobe mismatch: expected %p, actual %p", want, got);
               end
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   initial begin
      strobe_type   ignored_beat;
      cmd_item_type ones;
      int           sent;
      int           pick;
      ignored_beat = mk_strobe(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1);
      ones = mk_cmd(CMD_WREG, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                    8'hFF);

      // sample with nothing pending, right after reset
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'hFF), 1'b1, ignored_beat);
      add_row(mk_cmd(CMD_WREG, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b1, mk_strobe(1'b1, 1'b0, 8'h00, 1'b1, '0, 1'b0, 1'b0, 1'b1));
      add_row(mk_cmd(CMD_WREG, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b1, mk_strobe(1'b1, 1'b0, 8'hFF, 1'b1, '0, 1'b0, 1'b0, 1'b1));
      add_row(mk_cmd(CMD_PIX, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b1, mk_strobe(1'b1, 1'b0, 8'h00, 1'b1, '0, 1'b0, 1'b0, 1'b1));
      add_row(mk_cmd(CMD_PIX, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000,
                     8'h00), 1'b1, mk_strobe(1'b1, 1'b0, 8'hFF, 1'b1, '0, 1'b0, 1'b0, 1'b1));
      add_row(mk_cmd(CMD_ADDR, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b0, '0);
      add_row(mk_cmd(CMD_ADDR, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF,
                     8'h00), 1'b1, mk_strobe(1'b1, 1'b0, 8'hFF, 1'b1, '0, 1'b0, 1'b0, 1'b1));
      // full read, all ones
      add_row(mk_cmd(CMD_RIDX, 8'hFF, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b0, '0);
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'hFF), 1'b1, mk_strobe(1'b1, 1'b1, 8'h00, 1'b0, '0, 1'b0, 1'b0, 1'b1));
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'hFF), 1'b1,
              mk_strobe(1'b1, 1'b1, 8'h00, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b1));
      // full read, all zeros
      add_row(mk_cmd(CMD_RIDX, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b0, '0);
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b0, '0);
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b1,
              mk_strobe(1'b1, 1'b1, 8'h00, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1));
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h5A), 1'b1, ignored_beat);
      // index phase restarts a pending read
      add_row(mk_cmd(CMD_RIDX, 8'h12, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b0, '0);
      add_row(mk_cmd(CMD_RIDX, 8'h34, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b0, '0);
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'hA5), 1'b0, '0);
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h3C), 1'b0, '0);
      // other command drops a half-done read
      add_row(mk_cmd(CMD_RIDX, 8'h40, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b0, '0);
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h81), 1'b0, '0);
      add_row(mk_cmd(CMD_WREG, 8'h5C, 16'hBEEF, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h00), 1'b0, '0);
      add_row(mk_cmd(CMD_RSMP, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                     8'h7E), 1'b1, ignored_beat);
      // undefined codes, dropped without a beat
      ones.command = CMD_RSV_FIRST;
      add_row(ones, 1'b0, '0);
      ones.command = CMD_RSV_MID;
      add_row(ones, 1'b0, '0);
      ones.command = CMD_RSV_LAST;
      add_row(ones, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_cmd(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].final_strobe);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 9;
            recv_idle_pct = 78;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 78;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(99);
         if (pick < 32) begin
            send_rand(CMD_RIDX);
            send_rand(CMD_RSMP);
            send_rand(CMD_RSMP);
            sent += 3;
         end else if (pick < 67) begin
            send_rand(rand_write_kind());
            sent += 1;
         end else if (pick < 75) begin
            send_rand(CMD_RSMP);
            sent += 1;
         end else if (pick < 87) begin
            send_rand(CMD_RIDX);
            sent += 1;
            if ($urandom_range(1) == 1) begin
               send_rand(CMD_RSMP);
               sent += 1;
            end
            if ($urandom_range(3) == 0) begin
               send_rand(CMD_RIDX);
            end else begin
               send_rand(rand_write_kind());
            end
            sent += 1;
         end else if (pick < 94) begin
            send_rand(CMD_RIDX);
            send_rand(CMD_RSMP);
            sent += 2;
         end else begin
            send_rand(3'($urandom_range(CMD_RSV_FIRST, CMD_RSV_LAST)));
            sent += 1;
         end
      end

      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (strobes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && strobes_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/lpbs_pkg.sv
rtl/core/lpbs_front.sv
rtl/core/lpbs_queue.sv
rtl/core/lpbs_back.sv
rtl/core/parallel_lcd_bus_sequencer_core.sv
bench/tb.sv
